// ===== hw/rtl/md5_short_message_rehash_top_assert.svh =====
// Assertion shorthands for the md5 rehash block.
// The using scope must provide clk and rst_n.
`ifndef MD5_SHORT_MESSAGE_REHASH_TOP_ASSERT_SVH
`define MD5_SHORT_MESSAGE_REHASH_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define MD5R_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5r check failed");

// cons must hold in the cycle after ante
`define MD5R_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5r check failed");

`endif

// ===== hw/rtl/md5r_pkg.sv =====
`default_nettype none

package md5r_pkg;

    localparam int MAX_MSG_BYTES = 32;
    localparam int STORE_WORDS   = (MAX_MSG_BYTES + 3) / 4;
    localparam int STORE_AW      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int CNT_W         = $clog2(MAX_MSG_BYTES + 1);
    localparam int LEN_W         = 6;

    localparam logic [LEN_W-1:0] HEX_LEN  = 6'd32;
    localparam logic [7:0]       PAD_BYTE = 8'h80;

    typedef logic [3:0][31:0] md5r_words_t;

    // index 0 is word A
    localparam md5r_words_t MD5R_IV = {32'h10325476, 32'h98badcfe,
                                       32'hefcdab89, 32'h67452301};

    localparam logic [31:0] MD5R_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5R_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic start;
    } md5r_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md5r_stat_t;

    // message word used by a round
    function automatic logic [3:0] md5r_msg_idx(input logic [5:0] round);
        logic [3:0] ii;
        logic [3:0] idx;
        ii = round[3:0];
        unique case (round[5:4])
            2'd0:    idx = ii;
            2'd1:    idx = {ii[1:0], 2'b00} + ii + 4'd1;
            2'd2:    idx = {ii[2:0], 1'b0} + ii + 4'd5;
            default: idx = {ii[0], 3'b000} - ii;
        endcase
        return idx;
    endfunction

    function automatic logic [4:0] md5r_shift(input logic [5:0] round);
        return MD5R_S[{round[5:4], round[1:0]}];
    endfunction

    function automatic logic [31:0] md5r_f(input logic [5:0] round,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
        logic [31:0] f;
        unique case (round[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] md5r_rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    // lowercase ascii hex digit
    function automatic logic [7:0] md5r_hex(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/md5r_in_if.sv =====
`default_nettype none

interface md5r_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       is_last;
    logic       no_data;

    modport source (output valid, output msg_byte, output is_last, output no_data,
                    input ready);
    modport sink (input valid, input msg_byte, input is_last, input no_data,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/md5r_out_if.sv =====
`default_nettype none

interface md5r_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
    logic        too_long;

    modport source (output valid, output digest_a, output digest_b, output digest_c,
                    output digest_d, output too_long, input ready);
    modport sink (input valid, input digest_a, input digest_b, input digest_c,
                  input digest_d, input too_long, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/md5r_cfg_if.sv =====
`default_nettype none

interface md5r_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] hash_passes;

    modport source (output valid, output hash_passes, input ready);
    modport sink (input valid, input hash_passes, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/md5r_core.sv =====
`default_nettype none
`include "md5_short_message_rehash_top_assert.svh"

// 64-round MD5 compression, each round split into a mix state and a rotate state.
module md5r_core (
    input  logic                clk,
    input  logic                rst_n,
    input  md5r_pkg::md5r_ctrl_t ctrl,
    output md5r_pkg::md5r_stat_t stat,
    output logic [3:0]          word_idx,
    input  logic [31:0]         msg_word,
    output md5r_pkg::md5r_words_t work
);
    import md5r_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_MIX, C_ROT} core_state_t;

    core_state_t state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    md5r_words_t work_reg, work_next;
    logic [31:0] sum_reg, sum_next;
    logic        done_reg, done_next;

    always_comb
    begin
        logic [31:0] f;
        logic [31:0] rot;
        state_next = state_reg;
        round_next = round_reg;
        work_next  = work_reg;
        sum_next   = sum_reg;
        done_next  = 1'b0;
        f   = md5r_f(round_reg, work_reg[1], work_reg[2], work_reg[3]);
        rot = md5r_rotl(sum_reg + f, md5r_shift(round_reg));
        unique case (state_reg)
            C_IDLE:
            begin
                if (ctrl.start)
                begin
                    work_next  = MD5R_IV;
                    round_next = '0;
                    state_next = C_MIX;
                end
            end
            C_MIX:
            begin
                sum_next   = work_reg[0] + MD5R_K[round_reg] + msg_word;
                state_next = C_ROT;
            end
            C_ROT:
            begin
                // a <- d, b <- b + rot, c <- b, d <- c
                work_next  = {work_reg[2], work_reg[1], work_reg[1] + rot, work_reg[3]};
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else
                begin
                    state_next = C_MIX;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            work_reg  <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            work_reg  <= work_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

    assign word_idx  = md5r_msg_idx(round_reg);
    assign work      = work_reg;
    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = done_reg;

    `MD5R_ASSERT_NOW(a_start_when_idle, ctrl.start, state_reg == C_IDLE)
    `MD5R_ASSERT_NOW(a_done_wraps, done_reg, (state_reg == C_IDLE) && (round_reg == 6'd0))
    `MD5R_ASSERT_NEXT(a_last_round_done, (state_reg == C_ROT) && (round_reg == 6'd63), done_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/md5_short_message_rehash_top.sv =====
// channel | dir | payload                                   | taken when
// msg     | in  | msg_byte[8], is_last, no_data             | valid & ready
// result  | out | digest_a..digest_d[32], too_long          | valid & ready
// cfg     | in  | hash_passes[8]                            | valid & ready
//
// Message bytes are taken one per cycle while idle. A last byte starts a pass
// unless the message overflowed: 64 core rounds, then the chain add. The
// digest follows the last of P passes; an overflowed message goes straight to
// the output state with a zero digest. Reset clears every register but the
// byte store, which holds garbage until written. A waiting digest does not
// block input, but the next one stalls input until it frees.
`default_nettype none
`include "md5_short_message_rehash_top_assert.svh"

module md5_short_message_rehash_top (
    input logic        clk,
    input logic        rst_n,
    md5r_in_if.sink    msg,
    md5r_out_if.source result,
    md5r_cfg_if.sink   cfg
);
    import md5r_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ADD, ST_OUT} top_state_t;

    // message byte store, four bytes per word
    logic [31:0] store_reg [STORE_WORDS];

    top_state_t       state_reg, state_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             overflow_reg, overflow_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             hex_mode_reg, hex_mode_next;
    logic [7:0]       pass_count_reg, pass_count_next;
    logic [7:0]       hash_passes_reg;
    md5r_words_t      chain_reg, chain_next;
    logic             start_reg, start_next;
    logic             out_valid_reg, out_valid_next;
    md5r_words_t      digest_reg, digest_next;
    logic             too_long_reg, too_long_next;

    md5r_ctrl_t  ctrl;
    md5r_stat_t  stat;
    logic [3:0]  word_idx;
    logic [31:0] msg_word;
    md5r_words_t work;

    logic             msg_take;
    logic             byte_fits;
    logic [7:0]       eff_passes;
    logic [STORE_AW+1:0] wr_pos;

    assign msg.ready  = (state_reg == ST_IDLE);
    assign msg_take   = msg.valid && msg.ready;
    assign cfg.ready  = 1'b1;
    assign byte_fits  = (byte_count_reg < CNT_W'(MAX_MSG_BYTES));
    assign eff_passes = (hash_passes_reg == 8'd0) ? 8'd1 : hash_passes_reg;
    assign wr_pos     = (STORE_AW + 2)'(byte_count_reg);
    assign ctrl.start = start_reg;

    md5r_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .word_idx (word_idx),
        .msg_word (msg_word),
        .work     (work)
    );

    // store write; payload only, no reset
    always_ff @(posedge clk)
    begin
        if (msg_take && !msg.no_data && byte_fits)
        begin
            store_reg[wr_pos[STORE_AW+1:2]][8*wr_pos[1:0] +: 8] <= msg.msg_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_passes_reg <= 8'd1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            hash_passes_reg <= cfg.hash_passes;
        end
    end

    // Padded block word for the core. First pass reads the store, later
    // passes read the previous digest as hex text (len 32). Bytes past the
    // length are the pad byte then zeros; word 14 is the bit length.
    always_comb
    begin
        logic [31:0] raw;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [5:0]  pos;
        raw = '0;
        b0  = chain_reg[word_idx[2:1]][16*word_idx[0] +: 8];
        b1  = chain_reg[word_idx[2:1]][16*word_idx[0] + 8 +: 8];
        if (hex_mode_reg)
        begin
            if (!word_idx[3])
            begin
                raw = {md5r_hex(b1[3:0]), md5r_hex(b1[7:4]),
                       md5r_hex(b0[3:0]), md5r_hex(b0[7:4])};
            end
        end
        else if ({1'b0, word_idx} < 5'(STORE_WORDS))
        begin
            raw = store_reg[word_idx[STORE_AW-1:0]];
        end
        msg_word = '0;
        for (int k = 0; k < 4; k++)
        begin
            pos = {word_idx, 2'(k)};
            if (pos < len_reg)
            begin
                msg_word[8*k +: 8] = raw[8*k +: 8];
            end
            else if (pos == len_reg)
            begin
                msg_word[8*k +: 8] = PAD_BYTE;
            end
        end
        if (word_idx == 4'd14)
        begin
            msg_word = 32'({len_reg, 3'b000});
        end
        else if (word_idx == 4'd15)
        begin
            msg_word = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        overflow_next   = overflow_reg;
        len_next        = len_reg;
        hex_mode_next   = hex_mode_reg;
        pass_count_next = pass_count_reg;
        chain_next      = chain_reg;
        start_next      = 1'b0;
        out_valid_next  = out_valid_reg && !result.ready;
        digest_next     = digest_reg;
        too_long_next   = too_long_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_take)
                begin
                    if (!msg.no_data)
                    begin
                        if (byte_fits)
                        begin
                            byte_count_next = byte_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    if (msg.is_last)
                    begin
                        len_next        = LEN_W'(byte_count_next);
                        hex_mode_next   = 1'b0;
                        pass_count_next = 8'd1;
                        if (overflow_next)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            start_next = 1'b1;
                            state_next = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (stat.done)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_next[i] = MD5R_IV[i] + work[i];
                end
                if (pass_count_reg < eff_passes)
                begin
                    pass_count_next = pass_count_reg + 8'd1;
                    hex_mode_next   = 1'b1;
                    len_next        = HEX_LEN;
                    start_next      = 1'b1;
                    state_next      = ST_RUN;
                end
                else
                begin
                    pass_count_next = 8'd0;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    too_long_next   = overflow_reg;
                    digest_next     = overflow_reg ? '0 : chain_reg;
                    byte_count_next = '0;
                    overflow_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_count_reg <= '0;
            overflow_reg   <= 1'b0;
            len_reg        <= '0;
            hex_mode_reg   <= 1'b0;
            pass_count_reg <= '0;
            chain_reg      <= '0;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            digest_reg     <= '0;
            too_long_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            overflow_reg   <= overflow_next;
            len_reg        <= len_next;
            hex_mode_reg   <= hex_mode_next;
            pass_count_reg <= pass_count_next;
            chain_reg      <= chain_next;
            start_reg      <= start_next;
            out_valid_reg  <= out_valid_next;
            digest_reg     <= digest_next;
            too_long_reg   <= too_long_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.digest_a = digest_reg[0];
    assign result.digest_b = digest_reg[1];
    assign result.digest_c = digest_reg[2];
    assign result.digest_d = digest_reg[3];
    assign result.too_long = too_long_reg;

    `MD5R_ASSERT_NOW(a_done_in_run, stat.done, state_reg == ST_RUN)
    `MD5R_ASSERT_NOW(a_hex_len, hex_mode_reg, len_reg == HEX_LEN)
    `MD5R_ASSERT_NOW(a_too_long_zero, out_valid_reg && too_long_reg, digest_reg == '0)
    `MD5R_ASSERT_NOW(a_core_idle_outside_run, state_reg != ST_RUN, !stat.busy)

endmodule

`default_nettype wire
